// ===== rtl/rls_pkg.sv =====
// ----------------------------------------------------------------------------
// rls_pkg
// Shared types, constants and fixed-point helpers for the two-parameter
// RLS estimator.
// ----------------------------------------------------------------------------
package rls_pkg;

    localparam int FRAC_BITS  = 32;
    localparam int SW         = 64;
    localparam int COEFF_FRAC = 30;
    localparam int PROD_W     = 2 * SW;
    localparam int HALF_W     = SW / 2;

    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] ONE  = {{(SW-FRAC_BITS-1){1'b0}}, 1'b1,
                                            {FRAC_BITS{1'b0}}};

    typedef logic signed [SW-1:0] st_t;

    // register indexes
    typedef enum logic [1:0] {
        REG_POLE  = 2'd0,
        REG_GAIN  = 2'd1,
        REG_COV   = 2'd2,
        REG_PCONST = 2'd3
    } reg_idx_t;

    // datapath operand selectors
    typedef enum logic [4:0] {
        OP_FILT_V0, OP_FILT_V1, OP_FILT_V2,
        OP_FILT_I0, OP_FILT_I1, OP_FILT_I2,
        OP_T0A, OP_T0B, OP_T1A, OP_T1B,
        OP_DENA, OP_DENB,
        OP_U0A, OP_U0B, OP_U1A, OP_U1B,
        OP_P00, OP_P01, OP_P10, OP_P11,
        OP_EA, OP_EB, OP_A0, OP_A1
    } mop_t;

    typedef enum logic [1:0] {
        DV_G0, DV_G1, DV_RS, DV_LD
    } dop_t;

    typedef enum logic [4:0] {
        S_IDLE, S_RESTART, S_MUL, S_MUL_WAIT, S_DIV, S_DIV_WAIT, S_OUT
    } state_t;

    typedef struct packed {
        logic  restart;
        logic  mul_start;
        mop_t  mul_op;
        logic  div_start;
        dop_t  div_op;
        logic  capture_in;
        logic  load_out;
    } ctl_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic a0_zero;
    } sts_t;

    function automatic logic [SW-1:0] mag(input st_t x);
        mag = x[SW-1] ? (~x + 1'b1) : x;
    endfunction

    // saturating from sign + wide magnitude
    function automatic st_t from_mag(input logic neg, input logic [PROD_W-1:0] m);
        logic ovf;
        ovf = |m[PROD_W-1:SW];
        if (!neg) begin
            from_mag = (ovf || m[SW-1]) ? SMAX : st_t'(m[SW-1:0]);
        end else begin
            if (ovf || (m[SW-1] && |m[SW-2:0])) from_mag = SMIN;
            else from_mag = st_t'(~m[SW-1:0] + 1'b1);
        end
    endfunction

    function automatic st_t sadd(input st_t a, input st_t b);
        logic signed [SW:0] s;
        s = {a[SW-1], a} + {b[SW-1], b};
        if (s[SW] != s[SW-1]) sadd = s[SW] ? SMIN : SMAX;
        else sadd = s[SW-1:0];
    endfunction

    function automatic st_t ssub(input st_t a, input st_t b);
        logic signed [SW:0] s;
        s = {a[SW-1], a} - {b[SW-1], b};
        if (s[SW] != s[SW-1]) ssub = s[SW] ? SMIN : SMAX;
        else ssub = s[SW-1:0];
    endfunction

    function automatic st_t sample_to_state(input logic signed [31:0] x);
        logic [31:0] m;
        m = x[31] ? (~x + 1'b1) : x;
        sample_to_state = from_mag(x[31],
            PROD_W'({m, {(FRAC_BITS-16){1'b0}}}));
    endfunction

    // a 31-bit whole number always fits the 32 integer bits
    function automatic st_t int_to_state(input logic [30:0] x);
        int_to_state = st_t'({x, {FRAC_BITS{1'b0}}});
    endfunction

endpackage

// ===== rtl/rls_mul.sv =====
// ----------------------------------------------------------------------------
// rls_mul
// Signed saturating fractional multiplier: four 32x32 partial products,
// one per cycle, then shift, truncate toward zero and saturate.
// ----------------------------------------------------------------------------
module rls_mul
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rls_pkg::st_t      a,
    input  rls_pkg::st_t      b,
    input  logic              coeff_shift,
    output rls_pkg::st_t      result,
    output logic              done
);
    import rls_pkg::*;

    logic [SW-1:0]     ma_reg, mb_reg;
    logic              neg_reg, sh_reg;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [2:0]        step_reg, step_next;
    logic              busy_reg, busy_next;
    logic [HALF_W-1:0] opa, opb;
    logic [SW-1:0]     pp;
    logic [PROD_W-1:0] shifted;
    st_t               result_reg, result_next;
    logic              done_reg, done_next;

    always_comb
    begin
        opa = step_reg[0] ? ma_reg[SW-1:HALF_W] : ma_reg[HALF_W-1:0];
        opb = step_reg[1] ? mb_reg[SW-1:HALF_W] : mb_reg[HALF_W-1:0];
        pp  = opa * opb;
        shifted = sh_reg ? (acc_reg >> COEFF_FRAC) : (acc_reg >> FRAC_BITS);
    end

    always_comb
    begin
        acc_next    = acc_reg;
        step_next   = step_reg;
        busy_next   = busy_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        if (busy_reg) begin
            if (step_reg == 3'd4) begin
                result_next = from_mag(neg_reg, shifted);
                done_next   = 1'b1;
                busy_next   = 1'b0;
            end else begin
                acc_next  = acc_reg + (PROD_W'(pp) <<
                            (HALF_W * (32'(step_reg[0]) + 32'(step_reg[1]))));
                step_next = step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= done_next;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else begin
                busy_reg <= busy_next;
                step_reg <= step_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (start) begin
            ma_reg  <= mag(a);
            mb_reg  <= mag(b);
            neg_reg <= a[SW-1] ^ b[SW-1];
            sh_reg  <= coeff_shift;
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;
endmodule

// ===== rtl/rls_div.sv =====
// ----------------------------------------------------------------------------
// rls_div
// Signed saturating fractional divider, restoring, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rls_div
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  rls_pkg::st_t  n,
    input  rls_pkg::st_t  d,
    output rls_pkg::st_t  result,
    output logic          done
);
    import rls_pkg::*;

    logic [PROD_W-1:0] num_reg;
    logic [PROD_W-1:0] quo_reg;
    logic [SW-1:0]     rem_reg, md_reg;
    logic              neg_reg, dz_reg, nz_reg;
    logic [7:0]        cnt_reg;
    logic              busy_reg, done_reg;
    st_t               result_reg;
    logic [SW:0]       trial;
    logic              ge;
    logic [SW-1:0]     mn;

    assign mn    = mag(n);
    assign trial = {rem_reg, num_reg[PROD_W-1]};
    assign ge    = trial >= {1'b0, md_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 8'(PROD_W);
            end else if (busy_reg) begin
                if (cnt_reg == 8'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            num_reg <= PROD_W'(mn) << FRAC_BITS;
            md_reg  <= mag(d);
            neg_reg <= n[SW-1] ^ d[SW-1];
            dz_reg  <= (d == '0);
            nz_reg  <= (n == '0);
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            if (cnt_reg != 8'd0) begin
                num_reg <= num_reg << 1;
                rem_reg <= ge ? SW'(trial - {1'b0, md_reg}) : trial[SW-1:0];
                quo_reg <= {quo_reg[PROD_W-2:0], ge};
            end else if (dz_reg) begin
                result_reg <= nz_reg ? '0 : (neg_reg ? SMIN : SMAX);
            end else begin
                result_reg <= from_mag(neg_reg, quo_reg);
            end
        end
    end

    assign result = result_reg;
    assign done   = done_reg;
endmodule

// ===== rtl/rls_datapath.sv =====
// ----------------------------------------------------------------------------
// rls_datapath
// Estimator state, operand selection and the shared multiplier and divider.
// ----------------------------------------------------------------------------
module rls_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rls_pkg::ctl_t        ctl,
    output rls_pkg::sts_t        sts,
    input  logic                 in_mode,
    input  logic signed [31:0]   in_v,
    input  logic signed [31:0]   in_i,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_idx,
    input  logic [31:0]          cfg_data,
    output logic [320:0]         out_word
);
    import rls_pkg::*;

    logic signed [31:0] pole_reg, gain_reg;
    logic [30:0]        icov_reg;
    logic [15:0]        pconst_reg;
    logic signed [31:0] pv_reg, pi_reg, v_reg, i_reg;
    logic               mode_reg;
    st_t r0_reg, r1_reg, a0_reg, a1_reg;
    st_t p00_reg, p01_reg, p10_reg, p11_reg;
    st_t t0_reg, t1_reg, den_reg, g0_reg, g1_reg, err_reg, rs_reg, ld_reg;
    st_t acc_reg;
    st_t ma, mb, dn, dd, mres, dres;
    logic mcs;
    logic mul_done, div_done, a0_zero;
    st_t icov_st;
    logic [320:0] out_reg;

    assign icov_st = int_to_state(icov_reg);

    always_comb
    begin
        ma = t0_reg; mb = g0_reg; mcs = 1'b0;
        case (ctl.mul_op)
            OP_FILT_V0: begin ma = st_t'(pole_reg); mb = r0_reg; mcs = 1'b1; end
            OP_FILT_V1: begin ma = st_t'(gain_reg); mb = sample_to_state(v_reg); mcs = 1'b1; end
            OP_FILT_V2: begin ma = st_t'(gain_reg); mb = sample_to_state(pv_reg); mcs = 1'b1; end
            OP_FILT_I0: begin ma = st_t'(pole_reg); mb = r1_reg; mcs = 1'b1; end
            OP_FILT_I1: begin ma = st_t'(gain_reg); mb = sample_to_state(i_reg); mcs = 1'b1; end
            OP_FILT_I2: begin ma = st_t'(gain_reg); mb = sample_to_state(pi_reg); mcs = 1'b1; end
            OP_T0A, OP_U0A: begin ma = r0_reg; mb = p00_reg; end
            OP_T0B:  begin ma = r1_reg; mb = p01_reg; end
            OP_T1A:  begin ma = r0_reg; mb = p10_reg; end
            OP_T1B, OP_U1B: begin ma = r1_reg; mb = p11_reg; end
            OP_DENA: begin ma = r0_reg; mb = t0_reg; end
            OP_DENB: begin ma = r1_reg; mb = t1_reg; end
            OP_U0B:  begin ma = r1_reg; mb = p10_reg; end
            OP_U1A:  begin ma = r0_reg; mb = p01_reg; end
            OP_P00:  begin ma = t0_reg; mb = g0_reg; end
            OP_P01:  begin ma = t1_reg; mb = g0_reg; end
            OP_P10:  begin ma = t0_reg; mb = g1_reg; end
            OP_P11:  begin ma = t1_reg; mb = g1_reg; end
            OP_EA:   begin ma = r0_reg; mb = a0_reg; end
            OP_EB:   begin ma = r1_reg; mb = a1_reg; end
            OP_A0:   begin ma = g0_reg; mb = err_reg; end
            OP_A1:   begin ma = g1_reg; mb = err_reg; end
            default: begin ma = t0_reg; mb = g0_reg; end
        endcase
        case (ctl.div_op)
            DV_G0:   begin dn = t0_reg; dd = den_reg; end
            DV_G1:   begin dn = t1_reg; dd = den_reg; end
            DV_RS:   begin dn = ssub(int_to_state(31'(pconst_reg)), a1_reg); dd = a0_reg; end
            default: begin dn = ONE; dd = a0_reg; end
        endcase
    end

    rls_mul u_mul (.clk, .rst_n, .start(ctl.mul_start), .a(ma), .b(mb),
                   .coeff_shift(mcs), .result(mres), .done(mul_done));
    rls_div u_div (.clk, .rst_n, .start(ctl.div_start), .n(dn), .d(dd),
                   .result(dres), .done(div_done));

    assign a0_zero = (a0_reg == '0);
    assign sts = '{mul_done: mul_done, div_done: div_done, a0_zero: a0_zero};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pole_reg   <= 32'sd1064121097;
            gain_reg   <= 32'sd53447;
            icov_reg   <= 31'd9000000;
            pconst_reg <= 16'd90;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_idx))
                REG_POLE:   pole_reg   <= cfg_data;
                REG_GAIN:   gain_reg   <= cfg_data;
                REG_COV:    icov_reg   <= cfg_data[30:0];
                REG_PCONST: pconst_reg <= cfg_data[15:0];
                default:    ;
            endcase
        end
    end

    // state registers; restart re-initializes, mul and div results fold in per op
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pv_reg <= '0; pi_reg <= '0; r0_reg <= '0; r1_reg <= '0;
            a0_reg <= '0; a1_reg <= '0;
            p00_reg <= SW'(64'd9000000 << FRAC_BITS); p01_reg <= '0;
            p10_reg <= '0; p11_reg <= SW'(64'd9000000 << FRAC_BITS);
            mode_reg <= 1'b0; v_reg <= '0; i_reg <= '0; acc_reg <= '0;
            t0_reg <= '0; t1_reg <= '0; den_reg <= '0; g0_reg <= '0; g1_reg <= '0;
            err_reg <= '0; rs_reg <= '0; ld_reg <= '0;
            out_reg <= '0;
        end else begin
            if (ctl.restart) begin
                pv_reg <= '0; pi_reg <= '0; r0_reg <= '0; r1_reg <= '0;
                a0_reg <= '0; a1_reg <= '0;
                p00_reg <= icov_st; p01_reg <= '0; p10_reg <= '0; p11_reg <= icov_st;
            end
            if (mul_done) begin
                case (ctl.mul_op)
                    OP_FILT_V0, OP_FILT_I0, OP_T0A, OP_T1A, OP_DENA,
                    OP_U0A, OP_U1A, OP_EA: acc_reg <= mres;
                    OP_FILT_V1, OP_FILT_I1: acc_reg <= sadd(acc_reg, mres);
                    OP_FILT_V2: begin r0_reg <= sadd(acc_reg, mres); pv_reg <= v_reg; end
                    OP_FILT_I2: begin r1_reg <= sadd(acc_reg, mres); pi_reg <= i_reg; end
                    OP_T0B:  t0_reg <= sadd(acc_reg, mres);
                    OP_T1B:  t1_reg <= sadd(acc_reg, mres);
                    OP_DENB: den_reg <= sadd(sadd(acc_reg, mres), ONE);
                    OP_U0B:  t0_reg <= sadd(acc_reg, mres);
                    OP_U1B:  t1_reg <= sadd(acc_reg, mres);
                    OP_P00:  p00_reg <= ssub(p00_reg, mres);
                    OP_P01:  p01_reg <= ssub(p01_reg, mres);
                    OP_P10:  p10_reg <= ssub(p10_reg, mres);
                    OP_P11:  p11_reg <= ssub(p11_reg, mres);
                    OP_EB:   err_reg <= ssub(sample_to_state(i_reg), sadd(acc_reg, mres));
                    OP_A0:   a0_reg <= sadd(a0_reg, mres);
                    OP_A1:   a1_reg <= sadd(a1_reg, mres);
                    default: ;
                endcase
            end
            if (div_done) begin
                case (ctl.div_op)
                    DV_G0:   g0_reg <= dres;
                    DV_G1:   g1_reg <= dres;
                    DV_RS:   rs_reg <= dres;
                    default: ld_reg <= dres;
                endcase
            end
            if (ctl.capture_in) begin
                mode_reg <= in_mode; v_reg <= in_v; i_reg <= in_i;
                rs_reg <= '0; ld_reg <= '0;
            end
            if (ctl.load_out) begin
                if (mode_reg) out_reg <= '0;
                else out_reg <= {~a0_zero, ld_reg, rs_reg, err_reg, a1_reg, a0_reg};
            end
        end
    end

    assign out_word = out_reg;
endmodule

// ===== rtl/rls_ctrl.sv =====
// ----------------------------------------------------------------------------
// rls_ctrl
// Sequencer: walks the multiply and divide schedule of one RLS step.
// ----------------------------------------------------------------------------
module rls_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic           in_mode,
    input  logic           out_free,
    output logic           in_ready,
    output logic           out_load,
    output rls_pkg::ctl_t  ctl,
    input  rls_pkg::sts_t  sts
);
    import rls_pkg::*;

    state_t state_reg, state_next;
    mop_t   mop_reg, mop_next;
    dop_t   dop_reg, dop_next;

    always_comb
    begin
        state_next = state_reg;
        mop_next   = mop_reg;
        dop_next   = dop_reg;
        case (state_reg)
            S_IDLE: if (in_fire) begin
                state_next = in_mode ? S_RESTART : S_MUL;
                mop_next = OP_FILT_V0;
            end
            S_RESTART: state_next = S_OUT;
            S_MUL: state_next = S_MUL_WAIT;
            S_MUL_WAIT: if (sts.mul_done) begin
                case (mop_reg)
                    OP_DENB: begin state_next = S_DIV; dop_next = DV_G0; end
                    OP_A1: begin
                        // a0 is registered by now
                        if (sts.a0_zero) state_next = S_OUT;
                        else begin state_next = S_DIV; dop_next = DV_RS; end
                    end
                    default: begin state_next = S_MUL; mop_next = mop_t'(mop_reg + 5'd1); end
                endcase
            end
            S_DIV: state_next = S_DIV_WAIT;
            S_DIV_WAIT: if (sts.div_done) begin
                case (dop_reg)
                    DV_G0: begin state_next = S_DIV; dop_next = DV_G1; end
                    DV_G1: begin state_next = S_MUL; mop_next = OP_U0A; end
                    DV_RS: begin state_next = S_DIV; dop_next = DV_LD; end
                    default: state_next = S_OUT;
                endcase
            end
            S_OUT: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        ctl.mul_op = mop_reg;
        ctl.div_op = dop_reg;
        ctl.capture_in = (state_reg == S_IDLE) && in_fire;
        ctl.restart    = (state_reg == S_RESTART);
        ctl.mul_start  = (state_reg == S_MUL);
        ctl.div_start  = (state_reg == S_DIV);
        ctl.load_out   = (state_reg == S_OUT) && out_free;
        in_ready = (state_reg == S_IDLE);
        out_load = ctl.load_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            mop_reg   <= OP_FILT_V0;
            dop_reg   <= DV_G0;
        end else begin
            state_reg <= state_next;
            mop_reg   <= mop_next;
            dop_reg   <= dop_next;
        end
    end
endmodule

// ===== rtl/rls_two_param_estimator.sv =====
// ----------------------------------------------------------------------------
// rls_two_param_estimator
// Two-parameter recursive least squares estimator with bilinear prefilter.
// ----------------------------------------------------------------------------
// One item at a time. A sample beat runs 24 saturating multiplies on a shared
// 32x32 multiplier and two or four 128-bit restoring divides; a restart beat
// runs none. The result sits in an output register, so the next beat is taken
// while the previous result still waits on the master side.
module rls_two_param_estimator
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // voltage_sample[31:0], current_sample[63:32]
    input  logic         s_tuser,   // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    // param_slope, param_offset, prediction_error, resistance_estimate,
    // inductance_estimate, 64 bits each from bit 0 up
    output logic [319:0] m_tdata,
    output logic         m_tuser,   // estimate_valid
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import rls_pkg::*;

    ctl_t ctl;
    sts_t sts;
    logic in_ready, out_load, valid_reg;
    logic [320:0] word;

    rls_ctrl u_ctrl (.clk, .rst_n, .in_fire(s_tvalid && in_ready),
                     .in_mode(s_tuser), .out_free(!valid_reg || m_tready),
                     .in_ready, .out_load, .ctl, .sts);

    rls_datapath u_dp (.clk, .rst_n, .ctl, .sts, .in_mode(s_tuser),
                       .in_v(s_tdata[31:0]), .in_i(s_tdata[63:32]),
                       .cfg_we, .cfg_idx(cfg_index), .cfg_data, .out_word(word));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else if (out_load) valid_reg <= 1'b1;
        else if (m_tready) valid_reg <= 1'b0;
    end

    assign s_tready = in_ready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = word[319:0];
    assign m_tuser  = word[320];
endmodule

// ===== verif/rls_two_param_estimator_tb.sv =====
// ----------------------------------------------------------------------------
// rls_two_param_estimator_tb
// Self-checking bench for the two-parameter RLS estimator. A bit-exact
// predictor tracks filter, covariance and parameter state and checks every
// result beat. Config changes happen only while the block is idle.
// ----------------------------------------------------------------------------
module rls_two_param_estimator_tb;
    import rls_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;      // voltage_sample[31:0], current_sample[63:32]
    logic         s_tuser;      // mode
    logic         m_tvalid;
    logic         m_tready;
    logic [319:0] m_tdata;      // slope, offset, error, resistance, inductance
    logic         m_tuser;      // estimate_valid
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    rls_two_param_estimator DUT (.*);

    typedef struct packed {
        logic        restart;
        logic [31:0] volt;
        logic [31:0] curr;
    } sample_t;

    typedef struct packed {
        logic         valid;
        logic [319:0] data;
    } estimate_t;

    localparam logic [63:0] MAXV = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] HI65 = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] LO65 = -HI65 - 65'sd1;

    // predictor state and config copy
    logic signed [63:0] pole_c, gain_c;
    logic [30:0]        init_cov;
    logic [15:0]        pole_k;
    logic signed [63:0] prev_v, prev_i;
    logic signed [63:0] phi [2];
    logic signed [63:0] theta [2];
    logic signed [63:0] cov [4];

    sample_t   pending_samples [$];
    estimate_t expected_estimates [$];
    int        mismatches;
    int        beats_seen;
    bit        hold_off;
    bit        no_idle;

    always #1 clk = ~clk;

    // ---------------- fixed-point helpers (independent of the RTL) ----------
    function automatic logic [63:0] absval(input logic signed [63:0] x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic signed [63:0] clamp(input logic neg, input logic [127:0] m);
        if (!neg) return (m > 128'(MAXV)) ? MAXV : m[63:0];
        if (m > 128'(MAXV) + 1) return ~MAXV;
        return 64'(-m[63:0]);
    endfunction

    function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 input int sh);
        logic [127:0] p;
        p = (128'(absval(a)) * 128'(absval(b))) >> sh;
        return clamp(a[63] != b[63], p);
    endfunction

    function automatic logic signed [63:0] qdiv(input logic signed [63:0] n,
                                                 input logic signed [63:0] d);
        logic [127:0] q;
        if (d == 0) return (n == 0) ? 64'sd0 : (n > 0 ? MAXV : ~MAXV);
        q = (128'(absval(n)) << 32) / 128'(absval(d));
        return clamp(n[63] != d[63], q);
    endfunction

    function automatic logic signed [63:0] qadd(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > HI65) return MAXV;
        if (s < LO65) return ~MAXV;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] qsub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        if (s > HI65) return MAXV;
        if (s < LO65) return ~MAXV;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] widen(input logic signed [63:0] x);
        return clamp(x[63], 128'(absval(x)) << 16);
    endfunction

    function automatic logic signed [63:0] whole(input logic [30:0] x);
        return 64'(x) << 32;
    endfunction

    function automatic logic signed [63:0] lowpass(input logic signed [63:0] r,
                                                    input logic signed [63:0] x,
                                                    input logic signed [63:0] xp);
        logic signed [63:0] s;
        s = qmul(pole_c, r, 30);
        s = qadd(s, qmul(gain_c, x, 30));
        return qadd(s, qmul(gain_c, xp, 30));
    endfunction

    task automatic clear_estimator();
        prev_v = 0; prev_i = 0;
        phi[0] = 0; phi[1] = 0; theta[0] = 0; theta[1] = 0;
        cov[0] = whole(init_cov); cov[1] = 0; cov[2] = 0; cov[3] = whole(init_cov);
    endtask

    // one RLS update; returns the expected result beat
    task automatic rls_update(input sample_t smp, output estimate_t est);
        logic signed [63:0] v, y, p0, p1, t0, t1, den, g0, g1, err, a0, a1, rs, ld;
        est = '0;
        if (smp.restart) begin
            clear_estimator();
            return;
        end
        v = $signed(smp.volt);
        y = $signed(smp.curr);
        phi[0] = lowpass(phi[0], widen(v), widen(prev_v));
        phi[1] = lowpass(phi[1], widen(y), widen(prev_i));
        prev_v = v; prev_i = y;
        p0 = phi[0]; p1 = phi[1];
        t0 = qadd(qmul(p0, cov[0], 32), qmul(p1, cov[1], 32));
        t1 = qadd(qmul(p0, cov[2], 32), qmul(p1, cov[3], 32));
        den = qadd(qadd(qmul(p0, t0, 32), qmul(p1, t1, 32)), ONE);
        g0 = qdiv(t0, den);
        g1 = qdiv(t1, den);
        t0 = qadd(qmul(p0, cov[0], 32), qmul(p1, cov[2], 32));
        t1 = qadd(qmul(p0, cov[1], 32), qmul(p1, cov[3], 32));
        cov[0] = qsub(cov[0], qmul(t0, g0, 32));
        cov[1] = qsub(cov[1], qmul(t1, g0, 32));
        cov[2] = qsub(cov[2], qmul(t0, g1, 32));
        cov[3] = qsub(cov[3], qmul(t1, g1, 32));
        err = qsub(widen(y), qadd(qmul(p0, theta[0], 32), qmul(p1, theta[1], 32)));
        theta[0] = qadd(theta[0], qmul(g0, err, 32));
        theta[1] = qadd(theta[1], qmul(g1, err, 32));
        a0 = theta[0]; a1 = theta[1];
        rs = 0; ld = 0;
        if (a0 != 0) begin
            rs = qdiv(qsub(whole(31'(pole_k)), a1), a0);
            ld = qdiv(ONE, a0);
        end
        est.valid = (a0 != 0);
        est.data  = {ld, rs, err, a1, a0};
    endtask

    // ---------------- driver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        estimate_t est;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                rls_update(pending_samples.pop_front(), est);
                expected_estimates.push_back(est);
            end
            // keep offering during a hold-off so the input backs up
            if ((!s_tvalid || s_tready) && pending_samples.size() != 0 &&
                (no_idle || hold_off || $urandom_range(99) >= 37)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {pending_samples[0].curr, pending_samples[0].volt};
                s_tuser  <= pending_samples[0].restart;
            end else if (!s_tvalid || s_tready) begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // pending_samples[0] is the beat on the bus; pop happens at acceptance
    // note: the driver offers index 0 only after the previous one popped
    // because a new offer needs !s_tvalid || s_tready in the same edge

    // ---------------- monitor ----------------
    always @(posedge clk or negedge rst_n)
    begin
        estimate_t want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                beats_seen++;
                if (expected_estimates.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %h", m_tdata);
                end else begin
                    want = expected_estimates.pop_front();
                    if (want.data !== m_tdata || want.valid !== m_tuser) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("beat %0d: exp %h/%b got %h/%b", beats_seen,
                                     want.data, want.valid, m_tdata, m_tuser);
                    end
                end
            end
            m_tready <= !hold_off && (no_idle || $urandom_range(99) >= 37);
        end
    end

    // ---------------- stimulus helpers ----------------
    function automatic logic [31:0] rand_sample();
        case ($urandom_range(5))
            0: return $urandom;
            1: return {$urandom} >> $urandom_range(31);
            2: return -({$urandom} >> $urandom_range(31));
            default: return 32'($signed($urandom_range(40 << 16)) - (20 << 16));
        endcase
    endfunction

    task automatic push_sample(input logic rs, input logic [31:0] v, input logic [31:0] c);
        sample_t smp;
        smp.restart = rs; smp.volt = v; smp.curr = c;
        pending_samples.push_back(smp);
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || expected_estimates.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (800) @(posedge clk);
    endtask

    // one write strobe; cfg_we is low again before the next write
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_POLE:  pole_c   = $signed(val);
            REG_GAIN:  gain_c   = $signed(val);
            REG_COV:   init_cov = val[30:0];
            REG_PCONST: pole_k  = val[15:0];
            default:   ;
        endcase
        @(posedge clk);
    endtask

    task automatic random_run(input int n);
        repeat (n)
        begin
            if ($urandom_range(99) < 3) push_sample(1'b1, $urandom, $urandom);
            else push_sample(1'b0, rand_sample(), rand_sample());
        end
    endtask

    initial
    begin
        clk = 0; rst_n = 0;
        cfg_we = 0; cfg_index = REG_POLE; cfg_data = '0;
        hold_off = 0; no_idle = 0;
        mismatches = 0; beats_seen = 0;
        pole_c = 64'sd1064121097; gain_c = 64'sd53447; init_cov = 31'd9000000;
        pole_k = 16'd90;
        clear_estimator();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, restart, zero a0 on the first sample
        push_sample(1'b0, 32'h0, 32'h0);
        push_sample(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_sample(1'b0, 32'h8000_0000, 32'h8000_0000);
        push_sample(1'b0, 32'hFFFF_FFFF, 32'h0000_0001);
        push_sample(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_sample(1'b0, 32'h0001_0000, 32'h0000_8000);
        push_sample(1'b0, 32'h0002_0000, 32'hFFFF_0000);
        push_sample(1'b1, 32'h0, 32'h0);
        push_sample(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
        push_sample(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
        drain();

        // extreme config: large coefficients, huge covariance (saturates)
        write_reg(REG_POLE, 32'h7FFF_FFFF);
        write_reg(REG_GAIN, 32'h4000_0000);
        write_reg(REG_COV, 32'h7FFF_FFFF);
        write_reg(REG_PCONST, 32'h0000_FFFF);
        push_sample(1'b1, 32'h0, 32'h0);
        random_run(200);
        drain();

        write_reg(REG_POLE, 32'h8000_0000);
        write_reg(REG_GAIN, 32'h8000_0000);
        write_reg(REG_COV, 32'h0);
        write_reg(REG_PCONST, 32'h0);
        push_sample(1'b1, 32'h0, 32'h0);
        random_run(150);
        drain();

        // mid config, long run; receiver holds off to back up the block
        write_reg(REG_POLE, 32'd1064121097);
        write_reg(REG_GAIN, 32'd53447);
        write_reg(REG_COV, 32'd1000);
        write_reg(REG_PCONST, 32'd90);
        push_sample(1'b1, 32'h0, 32'h0);
        random_run(600);
        hold_off = 1;
        repeat (3000) @(posedge clk);
        hold_off = 0;
        no_idle = 1;
        repeat (20000) @(posedge clk);
        no_idle = 0;
        drain();

        write_reg(REG_POLE, $urandom);
        write_reg(REG_GAIN, $urandom_range(1 << 20));
        write_reg(REG_COV, $urandom_range(1 << 16));
        write_reg(REG_PCONST, $urandom);
        push_sample(1'b1, 32'h0, 32'h0);
        random_run(790);
        drain();

        if (mismatches == 0 && expected_estimates.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog: ~1750 beats plus stalls, with margin
    initial
    begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule
